FILE: design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/pst_pkg.sv
// Types and codes for the process slot table scheduler.
package pst_pkg;

    localparam logic [2:0] REQ_ALLOC    = 3'd0;
    localparam logic [2:0] REQ_COMMIT   = 3'd1;
    localparam logic [2:0] REQ_RELEASE  = 3'd2;
    localparam logic [2:0] REQ_DISPATCH = 3'd3;
    localparam logic [2:0] REQ_YIELD    = 3'd4;
    localparam logic [2:0] REQ_SLEEP    = 3'd5;
    localparam logic [2:0] REQ_WAKEUP   = 3'd6;

    localparam logic [2:0] RC_OK           = 3'd0;
    localparam logic [2:0] RC_FULL         = 3'd1;
    localparam logic [2:0] RC_NONE_READY   = 3'd2;
    localparam logic [2:0] RC_NONE_RUNNING = 3'd3;
    localparam logic [2:0] RC_BAD_STATE    = 3'd4;

    localparam logic [2:0] SS_UNUSED   = 3'd0;
    localparam logic [2:0] SS_EMBRYO   = 3'd1;
    localparam logic [2:0] SS_READY    = 3'd2;
    localparam logic [2:0] SS_RUNNING  = 3'd3;
    localparam logic [2:0] SS_SLEEPING = 3'd4;

    localparam logic [6:0] WOKEN_MAX = 7'd64;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [5:0]  slot;
        logic [31:0] channel;
    } req_t;

    typedef struct packed {
        logic [2:0]  status_code;
        logic [5:0]  slot_out;
        logic [31:0] pid;
        logic [6:0]  woken_count;
    } rsp_t;

endpackage

FILE: design/process_slot_table_scheduler.sv
// Process slot table scheduler: status and pid/channel memories with a scan sequencer.
// Yield, sleep and rejected items give their result in the cycle after acceptance; commit
// and release read the slot status, then check it and register the result; alloc and dispatch
// scan until a match or all NUM_SLOTS are read; wakeup always reads every slot, all through
// the one status read port. Items are taken one at a time, the next accepted once busy drops.
// Reset: a clearing pass writes every status entry unused, with busy high.
`include "assert_macros.svh"

module process_slot_table_scheduler
    import pst_pkg::*;
#(
    parameter int NUM_SLOTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t result
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(NUM_SLOTS);
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_SLOTS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    typedef struct packed {
        logic [31:0] pid;
        logic [31:0] chan;
    } info_t;

    logic [2:0] status_mem [NUM_SLOTS];
    info_t      info_mem   [NUM_SLOTS];
    logic [2:0] status_q;
    info_t      info_q;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] iss_addr_reg, iss_addr_next;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic          chk_last_reg, chk_last_next;
    logic [6:0]    woken_reg, woken_next;
    logic [31:0]   chan_reg, chan_next;
    logic [31:0]   pid_cnt_reg, pid_cnt_next;
    logic [AW-1:0] scan_pos_reg, scan_pos_next;
    logic [AW-1:0] run_slot_reg, run_slot_next;
    logic          run_valid_reg, run_valid_next;
    logic          done_reg, done_next;
    rsp_t          result_reg, result_next;

    logic          accept;
    logic [AW-1:0] rd_addr;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [2:0]    st_wdata;
    logic          pid_we, chan_we;
    logic [AW-1:0] info_waddr;
    logic [31:0]   info_wpid, info_wchan;
    logic          slot_in_range;

    assign accept = start && (state_reg == ST_IDLE);
    assign slot_in_range = 32'(req.slot) < 32'(NUM_SLOTS);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        clr_addr_next  = clr_addr_reg;
        iss_addr_next  = iss_addr_reg;
        iss_cnt_next   = iss_cnt_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        chk_last_next  = chk_last_reg;
        woken_next     = woken_reg;
        chan_next      = chan_reg;
        pid_cnt_next   = pid_cnt_reg;
        scan_pos_next  = scan_pos_reg;
        run_slot_next  = run_slot_reg;
        run_valid_next = run_valid_reg;
        done_next      = 1'b0;
        result_next    = '0;
        rd_addr        = iss_addr_reg;
        st_we          = 1'b0;
        st_waddr       = chk_addr_reg;
        st_wdata       = SS_UNUSED;
        pid_we         = 1'b0;
        chan_we        = 1'b0;
        info_waddr     = chk_addr_reg;
        info_wpid      = pid_cnt_reg;
        info_wchan     = chan_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_addr_reg;
                st_wdata = SS_UNUSED;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.req_type;
                    chan_next  = req.channel;
                    woken_next = '0;
                    case (req.req_type)
                        REQ_ALLOC, REQ_DISPATCH, REQ_WAKEUP:
                        begin
                            if (req.req_type == REQ_DISPATCH && run_valid_reg)
                            begin
                                done_next = 1'b1;
                                result_next.status_code = RC_BAD_STATE;
                            end
                            else
                            begin
                                rd_addr = (req.req_type == REQ_DISPATCH) ? scan_pos_reg : '0;
                                iss_addr_next  = (rd_addr == LAST_IDX) ? '0 : rd_addr + 1'b1;
                                iss_cnt_next   = CW'(1);
                                chk_valid_next = 1'b1;
                                chk_addr_next  = rd_addr;
                                chk_last_next  = (NUM_SLOTS == 1);
                                state_next     = ST_SCAN;
                            end
                        end
                        REQ_COMMIT, REQ_RELEASE:
                        begin
                            if (slot_in_range)
                            begin
                                rd_addr    = AW'(req.slot);
                                slot_next  = AW'(req.slot);
                                state_next = ST_CHECK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                result_next.status_code = RC_BAD_STATE;
                            end
                        end
                        REQ_YIELD, REQ_SLEEP:
                        begin
                            done_next = 1'b1;
                            if (!run_valid_reg)
                            begin
                                result_next.status_code = RC_NONE_RUNNING;
                            end
                            else
                            begin
                                st_we      = 1'b1;
                                st_waddr   = run_slot_reg;
                                info_waddr = run_slot_reg;
                                if (req.req_type == REQ_YIELD)
                                begin
                                    st_wdata = SS_READY;
                                end
                                else
                                begin
                                    st_wdata   = SS_SLEEPING;
                                    chan_we    = 1'b1;
                                    info_wchan = req.channel;
                                end
                                run_valid_next = 1'b0;
                                result_next.status_code = RC_OK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            result_next.status_code = RC_BAD_STATE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (iss_cnt_reg != CNT_FULL)
                begin
                    rd_addr        = iss_addr_reg;
                    iss_addr_next  = (iss_addr_reg == LAST_IDX) ? '0 : iss_addr_reg + 1'b1;
                    iss_cnt_next   = iss_cnt_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = iss_addr_reg;
                    chk_last_next  = (iss_cnt_reg == CNT_LAST);
                end
                if (chk_valid_reg)
                begin
                    case (op_reg)
                        REQ_ALLOC:
                        begin
                            if (status_q == SS_UNUSED)
                            begin
                                st_we    = 1'b1;
                                st_wdata = SS_EMBRYO;
                                pid_we   = 1'b1;
                                pid_cnt_next = pid_cnt_reg + 1'b1;
                                done_next  = 1'b1;
                                result_next.status_code = RC_OK;
                                result_next.slot_out    = 6'(chk_addr_reg);
                                result_next.pid         = pid_cnt_reg;
                                state_next = ST_IDLE;
                            end
                            else if (chk_last_reg)
                            begin
                                done_next  = 1'b1;
                                result_next.status_code = RC_FULL;
                                state_next = ST_IDLE;
                            end
                        end
                        REQ_DISPATCH:
                        begin
                            if (status_q == SS_READY)
                            begin
                                st_we          = 1'b1;
                                st_wdata       = SS_RUNNING;
                                run_slot_next  = chk_addr_reg;
                                run_valid_next = 1'b1;
                                scan_pos_next  = (chk_addr_reg == LAST_IDX) ? '0 :
                                                 chk_addr_reg + 1'b1;
                                done_next  = 1'b1;
                                result_next.status_code = RC_OK;
                                result_next.slot_out    = 6'(chk_addr_reg);
                                result_next.pid         = info_q.pid;
                                state_next = ST_IDLE;
                            end
                            else if (chk_last_reg)
                            begin
                                done_next  = 1'b1;
                                result_next.status_code = RC_NONE_READY;
                                state_next = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            if (status_q == SS_SLEEPING && info_q.chan == chan_reg)
                            begin
                                st_we    = 1'b1;
                                st_wdata = SS_READY;
                                if (woken_reg != WOKEN_MAX)
                                begin
                                    woken_next = woken_reg + 1'b1;
                                end
                            end
                            if (chk_last_reg)
                            begin
                                done_next  = 1'b1;
                                result_next.status_code = RC_OK;
                                result_next.woken_count = woken_next;
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (status_q == SS_EMBRYO)
                begin
                    st_we    = 1'b1;
                    st_waddr = slot_reg;
                    st_wdata = (op_reg == REQ_COMMIT) ? SS_READY : SS_UNUSED;
                    result_next.status_code = RC_OK;
                end
                else
                begin
                    result_next.status_code = RC_BAD_STATE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[st_waddr] <= st_wdata;
        end
        status_q <= status_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pid_we)
        begin
            info_mem[info_waddr].pid <= info_wpid;
        end
        if (chan_we)
        begin
            info_mem[info_waddr].chan <= info_wchan;
        end
        info_q <= info_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
            pid_cnt_reg   <= '0;
            scan_pos_reg  <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= chk_valid_next;
            pid_cnt_reg   <= pid_cnt_next;
            scan_pos_reg  <= scan_pos_next;
            run_slot_reg  <= run_slot_next;
            run_valid_reg <= run_valid_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        iss_addr_reg <= iss_addr_next;
        iss_cnt_reg  <= iss_cnt_next;
        chk_addr_reg <= chk_addr_next;
        chk_last_reg <= chk_last_next;
        woken_reg    <= woken_next;
        chan_reg     <= chan_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_IMPLIES(a_done_has_cause, done, $past(busy || start))
    `ASSERT_IMPLIES(a_no_dispatch_while_running,
                    state_reg == ST_SCAN && op_reg == REQ_DISPATCH, !run_valid_reg)
    `ASSERT_IMPLIES(a_fail_fields_zero, done && result.status_code != RC_OK,
                    result.pid == '0 && result.slot_out == '0 && result.woken_count == '0)
    `ASSERT_NEXT(a_yield_clears_running,
                 accept && (req.req_type == REQ_YIELD || req.req_type == REQ_SLEEP),
                 !run_valid_reg && done)

endmodule

FILE: verif/tb_process_slot_table_scheduler.sv
// Self-checking testbench for the process slot table scheduler with a built-in slot table predictor.
module tb_process_slot_table_scheduler;
    import pst_pkg::*;

    localparam int NUM_SLOTS = 64;
    localparam int NUM_RANDOM = 600;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] REQ_UNKNOWN = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic done;
    rsp_t result;

    req_t pending_items[$];
    rsp_t expected_results[$];
    int unsigned mismatches = 0;
    int unsigned gap_cycles = 0;
    int unsigned stall_cycles = 0;
    bit no_idle = 1'b0;

    logic [2:0]  tbl_status [NUM_SLOTS];
    logic [31:0] tbl_pid    [NUM_SLOTS];
    logic [31:0] tbl_chan   [NUM_SLOTS];
    logic [31:0] pid_seq;
    logic [5:0]  scan_pos;
    logic [5:0]  run_slot;
    logic        run_valid;
    logic [31:0] chan_pool  [4];

    process_slot_table_scheduler #(.NUM_SLOTS(NUM_SLOTS)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic rsp_t schedule_request(req_t r);
        rsp_t o;
        int   k;
        bit   found;
        o = '0;
        found = 1'b0;
        case (r.req_type)
            REQ_ALLOC:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && tbl_status[i] == SS_UNUSED)
                    begin
                        found = 1'b1;
                        tbl_status[i] = SS_EMBRYO;
                        tbl_pid[i] = pid_seq;
                        pid_seq = pid_seq + 32'd1;
                        o.slot_out = 6'(i);
                        o.pid = tbl_pid[i];
                    end
                end
                if (!found)
                    o.status_code = RC_FULL;
            end
            REQ_COMMIT, REQ_RELEASE:
            begin
                if (tbl_status[r.slot] != SS_EMBRYO)
                    o.status_code = RC_BAD_STATE;
                else
                    tbl_status[r.slot] = (r.req_type == REQ_COMMIT) ? SS_READY : SS_UNUSED;
            end
            REQ_DISPATCH:
            begin
                if (run_valid)
                    o.status_code = RC_BAD_STATE;
                else
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        k = (int'(scan_pos) + i) % NUM_SLOTS;
                        if (!found && tbl_status[k] == SS_READY)
                        begin
                            found = 1'b1;
                            tbl_status[k] = SS_RUNNING;
                            run_slot = 6'(k);
                            run_valid = 1'b1;
                            scan_pos = 6'((k + 1) % NUM_SLOTS);
                            o.slot_out = 6'(k);
                            o.pid = tbl_pid[k];
                        end
                    end
                    if (!found)
                        o.status_code = RC_NONE_READY;
                end
            end
            REQ_YIELD, REQ_SLEEP:
            begin
                if (!run_valid)
                    o.status_code = RC_NONE_RUNNING;
                else
                begin
                    if (r.req_type == REQ_YIELD)
                        tbl_status[run_slot] = SS_READY;
                    else
                    begin
                        tbl_chan[run_slot] = r.channel;
                        tbl_status[run_slot] = SS_SLEEPING;
                    end
                    run_valid = 1'b0;
                end
            end
            REQ_WAKEUP:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (tbl_status[i] == SS_SLEEPING && tbl_chan[i] == r.channel)
                    begin
                        tbl_status[i] = SS_READY;
                        o.woken_count = o.woken_count + 7'd1;
                    end
                end
            end
            default:
                o.status_code = RC_BAD_STATE;
        endcase
        return o;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    task automatic queue_item(logic [2:0] op, logic [5:0] s, logic [31:0] ch);
        req_t r;
        r.req_type = op;
        r.slot = s;
        r.channel = ch;
        pending_items.push_back(r);
    endtask

    // driver: holds start until the item is taken, then waits a drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            gap_cycles = $urandom_range(0, 5);
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(schedule_request(req));
                gap_cycles = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (!start || !busy)
            begin
                if (gap_cycles != 0)
                begin
                    gap_cycles--;
                    start <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    req <= pending_items.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item outstanding: 0x%0h", result);
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("status_code", 32'(exp_r.status_code), 32'(result.status_code));
                check_field("slot_out", 32'(exp_r.slot_out), 32'(result.slot_out));
                check_field("pid", exp_r.pid, result.pid);
                check_field("woken_count", 32'(exp_r.woken_count), 32'(result.woken_count));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int unsigned roll;
        int unsigned phase;
        logic [2:0]  op;
        logic [5:0]  s;
        logic [31:0] ch;
        int          picks[$];

        foreach (tbl_status[i])
        begin
            tbl_status[i] = SS_UNUSED;
            tbl_pid[i] = '0;
            tbl_chan[i] = '0;
        end
        pid_seq = '0;
        scan_pos = '0;
        run_slot = '0;
        run_valid = 1'b0;
        foreach (chan_pool[i])
            chan_pool[i] = $urandom();

        // empty table: nothing running, nothing ready, bad slots, unknown request
        queue_item(REQ_YIELD, 6'd0, 32'd0);
        queue_item(REQ_SLEEP, 6'd63, 32'hFFFF_FFFF);
        queue_item(REQ_DISPATCH, 6'd0, 32'd0);
        queue_item(REQ_COMMIT, 6'd0, 32'd0);
        queue_item(REQ_RELEASE, 6'd63, 32'hFFFF_FFFF);
        queue_item(REQ_UNKNOWN, 6'd63, 32'hFFFF_FFFF);
        queue_item(REQ_WAKEUP, 6'd0, 32'd0);
        // alloc, release and realloc of a hole
        queue_item(REQ_ALLOC, 6'd0, 32'd0);
        queue_item(REQ_ALLOC, 6'd0, 32'd0);
        queue_item(REQ_ALLOC, 6'd0, 32'd0);
        queue_item(REQ_RELEASE, 6'd1, 32'd0);
        queue_item(REQ_ALLOC, 6'd0, 32'd0);
        queue_item(REQ_COMMIT, 6'd0, 32'd0);
        queue_item(REQ_COMMIT, 6'd1, 32'd0);
        queue_item(REQ_COMMIT, 6'd0, 32'd0);
        // dispatch, dispatch while running, two sleepers on one channel
        queue_item(REQ_DISPATCH, 6'd0, 32'd0);
        queue_item(REQ_DISPATCH, 6'd0, 32'd0);
        queue_item(REQ_SLEEP, 6'd0, 32'hFFFF_FFFF);
        queue_item(REQ_DISPATCH, 6'd0, 32'd0);
        queue_item(REQ_SLEEP, 6'd0, 32'hFFFF_FFFF);
        queue_item(REQ_WAKEUP, 6'd0, 32'hFFFF_FFFF);
        // scan wraps past the embryo in slot 2
        queue_item(REQ_DISPATCH, 6'd0, 32'd0);
        queue_item(REQ_YIELD, 6'd0, 32'd0);
        queue_item(REQ_RELEASE, 6'd2, 32'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            while (pending_items.size() != 0)
                @(posedge clk);
            phase = n / 100;
            no_idle = (phase == 2);
            roll = $urandom_range(0, 99);
            if (phase >= 4)
                op = roll < 40 ? REQ_ALLOC : roll < 65 ? REQ_COMMIT : roll < 72 ? REQ_RELEASE :
                     roll < 82 ? REQ_DISPATCH : roll < 88 ? REQ_YIELD : roll < 94 ? REQ_SLEEP :
                     REQ_WAKEUP;
            else if (phase == 3)
                op = roll < 8 ? REQ_ALLOC : roll < 14 ? REQ_COMMIT : roll < 18 ? REQ_RELEASE :
                     roll < 45 ? REQ_DISPATCH : roll < 62 ? REQ_YIELD : roll < 80 ? REQ_SLEEP :
                     roll < 98 ? REQ_WAKEUP : REQ_UNKNOWN;
            else
                op = roll < 20 ? REQ_ALLOC : roll < 32 ? REQ_COMMIT : roll < 46 ? REQ_RELEASE :
                     roll < 64 ? REQ_DISPATCH : roll < 74 ? REQ_YIELD : roll < 84 ? REQ_SLEEP :
                     roll < 97 ? REQ_WAKEUP : REQ_UNKNOWN;

            picks.delete();
            foreach (tbl_status[i])
                if (tbl_status[i] == SS_EMBRYO)
                    picks.push_back(i);
            if (picks.size() != 0 && $urandom_range(0, 4) != 0)
                s = 6'(picks[$urandom_range(0, picks.size() - 1)]);
            else
                s = 6'($urandom_range(0, 63));

            ch = $urandom();
            if (op == REQ_SLEEP && $urandom_range(0, 3) != 0)
                ch = chan_pool[$urandom_range(0, 3)];
            if (op == REQ_WAKEUP)
            begin
                picks.delete();
                foreach (tbl_status[i])
                    if (tbl_status[i] == SS_SLEEPING)
                        picks.push_back(i);
                roll = $urandom_range(0, 9);
                if (picks.size() != 0 && roll < 6)
                    ch = tbl_chan[picks[$urandom_range(0, picks.size() - 1)]];
                else if (roll < 8)
                    ch = chan_pool[$urandom_range(0, 3)];
            end
            queue_item(op, s, ch);
        end
        no_idle = 1'b0;

        while (pending_items.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (NUM_SLOTS + 8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
